// ===== sv/ssp_pkg.sv =====
package ssp_pkg;

    localparam int unsigned ACC_W   = 64;
    localparam int unsigned SHIFT_W = 6;
    localparam int unsigned PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SUFFIX = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FAILED = 2'd2;

    localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] DIGIT_CUTOFF = (ACC_MAX - 64'd9) / 64'd10;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_K_LC = 8'h6B;
    localparam logic [7:0] CH_K_UC = 8'h4B;
    localparam logic [7:0] CH_M_LC = 8'h6D;
    localparam logic [7:0] CH_M_UC = 8'h4D;
    localparam logic [7:0] CH_G_LC = 8'h67;
    localparam logic [7:0] CH_G_UC = 8'h47;
    localparam logic [7:0] CH_T_LC = 8'h74;
    localparam logic [7:0] CH_T_UC = 8'h54;

    localparam logic [SHIFT_W-1:0] SH_NONE = 6'd0;
    localparam logic [SHIFT_W-1:0] SH_KILO = 6'd10;
    localparam logic [SHIFT_W-1:0] SH_MEGA = 6'd20;
    localparam logic [SHIFT_W-1:0] SH_GIGA = 6'd30;
    localparam logic [SHIFT_W-1:0] SH_TERA = 6'd40;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic [PHASE_W-1:0] phase;
        logic               saw_digit;
        logic [SHIFT_W-1:0] shift;
    } t_state;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic               good;
        logic [SHIFT_W-1:0] shift;
    } t_snap;

    localparam t_state STATE_RESET = '{acc: '0, phase: PH_DIGITS, saw_digit: 1'b0,
                                      shift: SH_NONE};

    function automatic logic [SHIFT_W-1:0] suffix_shift_of(input logic [7:0] ch);
        logic [SHIFT_W-1:0] sh;
        case (ch)
            CH_K_LC, CH_K_UC: sh = SH_KILO;
            CH_M_LC, CH_M_UC: sh = SH_MEGA;
            CH_G_LC, CH_G_UC: sh = SH_GIGA;
            CH_T_LC, CH_T_UC: sh = SH_TERA;
            default:          sh = SH_NONE;
        endcase
        return sh;
    endfunction

endpackage

// ===== sv/ssp_step.sv =====
module ssp_step import ssp_pkg::*; (
    input  t_state     i_state,
    input  logic [7:0] i_char,
    input  logic       i_end_only,
    output t_state     o_state
);

    logic [SHIFT_W-1:0] suffix_sh;
    logic [7:0]         digit;

    assign suffix_sh = suffix_shift_of(i_char);
    assign digit     = i_char - CH_ZERO;

    always_comb begin
        o_state = i_state;
        if (!i_end_only) begin
            case (i_state.phase)
                PH_DIGITS: begin
                    if (i_char inside {[CH_ZERO:CH_NINE]}) begin
                        o_state.saw_digit = 1'b1;
                        if (i_state.acc > DIGIT_CUTOFF) begin
                            o_state.phase = PH_FAILED;
                        end else begin
                            // times ten as two shifted copies
                            o_state.acc = (i_state.acc << 3) + (i_state.acc << 1)
                                        + {{(ACC_W-8){1'b0}}, digit};
                        end
                    end else if (!i_state.saw_digit) begin
                        o_state.phase = PH_FAILED;
                    end else if (suffix_sh == SH_NONE) begin
                        o_state.phase = PH_FAILED;
                    end else begin
                        o_state.shift = suffix_sh;
                        o_state.phase = PH_SUFFIX;
                    end
                end
                default: begin
                    // any byte after the suffix, or once failed
                    o_state.phase = PH_FAILED;
                end
            endcase
        end
    end

endmodule

// ===== sv/ssp_scale.sv =====
module ssp_scale import ssp_pkg::*; (
    input  t_snap             i_snap,
    output logic              o_ok,
    output logic [ACC_W-1:0]  o_value
);

    logic [ACC_W-1:0] limit;

    assign limit   = ACC_MAX >> i_snap.shift;
    assign o_ok    = i_snap.good && (i_snap.acc <= limit);
    assign o_value = o_ok ? (i_snap.acc << i_snap.shift) : '0;

endmodule

// ===== sv/size_string_parser_unit.sv =====
// Path of a tlast beat: input, snapshot, output register, o_m_axis_tvalid.
// Throughput: one beat per cycle unless a last beat meets full result regs;
// limit: accumulator update (x10, digit add, cutoff compare) in parse stage
// Reset: synchronous, active low; clears all stage valids and returns the
// parser to its empty-string state.
module size_string_parser_unit import ssp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] char_code
    input  logic              i_s_axis_tuser,   // [0] end_only
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [ACC_W-1:0]  o_m_axis_tdata,   // [63:0] size_value
    output logic              o_m_axis_tuser    // [0] ok
);

    logic              r_in_valid;
    logic [7:0]        r_in_char;
    logic              r_in_end_only;
    logic              r_in_last;

    t_state            r_state;
    t_state            n_state;

    logic              r_snap_valid;
    t_snap             r_snap;

    logic              r_out_valid;
    logic              r_out_ok;
    logic [ACC_W-1:0]  r_out_value;

    logic              scale_ok;
    logic [ACC_W-1:0]  scale_value;

    logic              out_free;
    logic              snap_free;
    logic              in_consume;
    logic              in_take;

    ssp_step u_step (
        .i_state    (r_state),
        .i_char     (r_in_char),
        .i_end_only (r_in_end_only),
        .o_state    (n_state)
    );

    ssp_scale u_scale (
        .i_snap  (r_snap),
        .o_ok    (scale_ok),
        .o_value (scale_value)
    );

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign snap_free  = !r_snap_valid || out_free;
    // only a last beat needs room downstream
    assign in_consume = r_in_valid && (!r_in_last || snap_free);
    assign in_take    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || in_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char     <= i_s_axis_tdata;
            r_in_end_only <= i_s_axis_tuser;
            r_in_last     <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_consume) begin
            r_state <= r_in_last ? STATE_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_free) begin
            r_snap_valid <= in_consume && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_consume && r_in_last) begin
            r_snap.acc   <= n_state.acc;
            r_snap.shift <= n_state.shift;
            r_snap.good  <= n_state.saw_digit &&
                            (n_state.phase == PH_DIGITS || n_state.phase == PH_SUFFIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_snap_valid) begin
            r_out_ok    <= scale_ok;
            r_out_value <= scale_value;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_ok;

    // hold a finished string while the output is stalled
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && r_out_valid && !i_m_axis_tready) |=> r_snap_valid)
        else $error("pending result dropped under stall");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("failed string carries a nonzero value");

    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_consume && r_in_last) |=>
            (r_state.acc == '0 && r_state.phase == PH_DIGITS && !r_state.saw_digit))
        else $error("parser not cleared after last beat");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_in_last && r_snap_valid && r_out_valid))
        else $error("input stalled without a full pipeline");

endmodule

// ===== test/tb_size_string_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_size_string_parser_unit;
    import ssp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 10;
    localparam int TAIL_BEATS  = 150;
    localparam int RANDOM_BEATS = 780;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_only;
        logic       last;
    } t_char_beat;

    typedef struct packed {
        logic             ok;
        logic [ACC_W-1:0] size_value;
    } t_size_result;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata  = 8'h00;   // [7:0] char_code
    logic             s_tuser  = 1'b0;    // [0] end_only
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [ACC_W-1:0] m_tdata;            // [63:0] size_value
    logic             m_tuser;            // [0] ok

    t_char_beat   char_beats_q[$];
    t_size_result size_results_q[$];
    logic [7:0]   text_q[$];

    // predictor state
    logic [ACC_W-1:0]   size_acc    = '0;
    logic [PHASE_W-1:0] parse_phase = PH_DIGITS;
    logic               saw_digit   = 1'b0;
    logic [SHIFT_W-1:0] size_shift  = SH_NONE;

    int  beats_made = 0;
    int  beats_in   = 0;
    int  n_errors   = 0;
    int  cycles     = 0;
    int  send_gap   = 0;
    int  rx_stall   = 0;
    logic in_fire   = 1'b0;
    logic hold_rx   = 1'b0;

    size_string_parser_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // case-fold the letter, then map it to its power of two
    function automatic logic [SHIFT_W-1:0] letter_shift(input logic [7:0] ch);
        logic [SHIFT_W-1:0] sh;
        case (ch | 8'h20)
            CH_K_LC: sh = SH_KILO;
            CH_M_LC: sh = SH_MEGA;
            CH_G_LC: sh = SH_GIGA;
            CH_T_LC: sh = SH_TERA;
            default: sh = SH_NONE;
        endcase
        return sh;
    endfunction

    task automatic parse_char_beat(input t_char_beat b);
        t_size_result r;
        logic [SHIFT_W-1:0] sh;
        if (!b.end_only) begin
            if (parse_phase == PH_DIGITS) begin
                if (b.ch >= CH_ZERO && b.ch <= CH_NINE) begin
                    saw_digit = 1'b1;
                    if (size_acc > DIGIT_CUTOFF)
                        parse_phase = PH_FAILED;
                    else
                        size_acc = size_acc * 64'd10 + {56'd0, b.ch - CH_ZERO};
                end else begin
                    sh = letter_shift(b.ch);
                    if (!saw_digit || sh == SH_NONE) begin
                        parse_phase = PH_FAILED;
                    end else begin
                        size_shift  = sh;
                        parse_phase = PH_SUFFIX;
                    end
                end
            end else begin
                parse_phase = PH_FAILED;
            end
        end
        if (b.last) begin
            r.ok         = 1'b0;
            r.size_value = '0;
            if ((parse_phase == PH_DIGITS || parse_phase == PH_SUFFIX) && saw_digit &&
                size_acc <= (ACC_MAX >> size_shift)) begin
                r.ok         = 1'b1;
                r.size_value = size_acc << size_shift;
            end
            size_results_q.push_back(r);
            size_acc    = '0;
            parse_phase = PH_DIGITS;
            saw_digit   = 1'b0;
            size_shift  = SH_NONE;
        end
    endtask

    function automatic logic [7:0] suffix_char(input int idx);
        case (idx)
            0:       return CH_K_LC;
            1:       return CH_K_UC;
            2:       return CH_M_LC;
            3:       return CH_M_UC;
            4:       return CH_G_LC;
            5:       return CH_G_UC;
            6:       return CH_T_LC;
            default: return CH_T_UC;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic push_beat(input logic [7:0] ch, input logic end_only, input logic last);
        t_char_beat b;
        b.ch       = ch;
        b.end_only = end_only;
        b.last     = last;
        char_beats_q.push_back(b);
        if (!end_only || last)
            beats_made++;
    endtask

    task automatic push_number(input logic [ACC_W-1:0] v);
        logic [7:0]       digs[$];
        logic [ACC_W-1:0] rem;
        do begin
            rem = v % 64'd10;
            digs.push_front(CH_ZERO + rem[7:0]);
            v = v / 64'd10;
        end while (v != 0);
        while (digs.size() != 0)
            text_q.push_back(digs.pop_front());
    endtask

    // send the text; end on its final byte or on an extra end-only beat
    task automatic emit_string(input bit end_beat);
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            push_beat(text_q[i], 1'b0, !end_beat && i == n - 1);
        end
        if (end_beat || n == 0)
            push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        text_q.delete();
    endtask

    task automatic build_directed();
        emit_string(1'b1);                                          // empty
        text_q.push_back(CH_ZERO);                      emit_string(1'b0);
        text_q.push_back(CH_NINE); text_q.push_back(CH_K_LC);  emit_string(1'b1);
        text_q.push_back(CH_ZERO + 8'd3); text_q.push_back(CH_M_UC); emit_string(1'b0);
        // byte after the suffix letter
        text_q.push_back(CH_ZERO + 8'd1); text_q.push_back(CH_G_LC);
        text_q.push_back(CH_T_UC);                      emit_string(1'b0);
        text_q.push_back(CH_ZERO + 8'd4); text_q.push_back(CH_T_LC);
        text_q.push_back(CH_ZERO + 8'd5);               emit_string(1'b0);
        text_q.push_back(8'hFF);                        emit_string(1'b0);
        text_q.push_back(CH_ZERO + 8'd2); text_q.push_back(8'h00);   emit_string(1'b0);
        // failed string keeps swallowing bytes
        text_q.push_back(8'h78); text_q.push_back(CH_ZERO + 8'd1);   emit_string(1'b1);
        push_beat(8'hFF, 1'b1, 1'b0);
        text_q.push_back(CH_ZERO + 8'd6); text_q.push_back(CH_G_UC); emit_string(1'b1);
        // 2^24 scaled by tera no longer fits
        push_number(64'd16777216); text_q.push_back(CH_T_UC);        emit_string(1'b0);
    endtask

    task automatic build_random();
        int               kind;
        int               nd;
        int               sh_sel;
        int               pick;
        logic [ACC_W-1:0] v;
        while (beats_made < RANDOM_BEATS) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                nd = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                repeat (nd) text_q.push_back(rand_digit());
                if ($urandom_range(0, 2) != 0)
                    text_q.push_back(suffix_char($urandom_range(0, 7)));
            end else if (kind < 72) begin
                // values around the digit cutoff and the scaled limit
                sh_sel = $urandom_range(0, 4);
                case ($urandom_range(0, 5))
                    0:       v = ACC_MAX >> (10 * sh_sel);
                    1:       v = (ACC_MAX >> (10 * sh_sel)) + 64'd1;
                    2:       v = DIGIT_CUTOFF;
                    3:       v = DIGIT_CUTOFF + 64'd1;
                    4:       v = DIGIT_CUTOFF * 64'd10 + 64'd9;
                    default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                endcase
                push_number(v);
                if ($urandom_range(0, 2) == 0)
                    text_q.push_back(rand_digit());
                if (sh_sel != 0)
                    text_q.push_back(suffix_char(2 * (sh_sel - 1) + $urandom_range(0, 1)));
            end else if (kind < 95) begin
                nd = $urandom_range(1, 6);
                repeat (nd) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        text_q.push_back(rand_digit());
                    else if (pick < 7)
                        text_q.push_back(suffix_char($urandom_range(0, 7)));
                    else
                        text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            emit_string($urandom_range(0, 3) == 0);
        end
    endtask

    // sender
    always @(negedge clk) begin : drive_chars
        t_char_beat b;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (char_beats_q.size() >= TAIL_BEATS && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 9);
                s_tvalid <= 1'b0;
            end else if (char_beats_q.size() != 0) begin
                b = char_beats_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.ch;
                s_tuser  <= b.end_only;
                s_tlast  <= b.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (char_beats_q.size() >= TAIL_BEATS && $urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // hold the result side off long enough to back up the input
    initial begin
        while (beats_in < 60) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk) begin : watch_chars
        t_char_beat b;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                b.ch       = s_tdata;
                b.end_only = s_tuser;
                b.last     = s_tlast;
                parse_char_beat(b);
                beats_in <= beats_in + 1;
            end
        end
    end

    always @(posedge clk) begin : check_sizes
        t_size_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (size_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result ok=%0b size=%0d", m_tuser, m_tdata));
            end else begin
                want = size_results_q.pop_front();
                if (m_tuser !== want.ok)
                    report_mismatch($sformatf("ok %0b, want %0b", m_tuser, want.ok));
                if (m_tdata !== want.size_value)
                    report_mismatch($sformatf("size %0d, want %0d", m_tdata, want.size_value));
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        build_directed();
        build_random();
        repeat (RESET_LEN) @(negedge clk);
        rst_n <= 1'b1;
        while (char_beats_q.size() != 0 || s_tvalid) @(posedge clk);
        while (size_results_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
